>>> design/rau_pkg.sv
// Package: opcodes, payload structs and widths for the rational arithmetic unit.
package rau_pkg;

	localparam int WORD_BITS_DEF = 32;
	localparam int FIELD_BITS = 32;

	typedef enum logic [3:0] {
		OP_ADD      = 4'd0,
		OP_SUB      = 4'd1,
		OP_MUL      = 4'd2,
		OP_NEG      = 4'd3,
		OP_EQ       = 4'd4,
		OP_GT       = 4'd5,
		OP_LT       = 4'd6,
		OP_SIMP     = 4'd7,
		OP_IS_SIMP  = 4'd8
	} op_t;

	typedef struct packed {
		logic [3:0]         opcode;
		logic signed [31:0] a_num;
		logic signed [31:0] a_den;
		logic signed [31:0] b_num;
		logic signed [31:0] b_den;
	} in_beat_t;

	typedef struct packed {
		logic signed [31:0] res_num;
		logic signed [31:0] res_den;
		logic               flag;
		logic               status;
	} out_beat_t;

endpackage

>>> design/rational_arithmetic_unit.sv
// Top level: rational arithmetic unit with a shared multiplier and shift/subtract unit.
//
// Input channel (in_valid/in_stall/in_data) takes one opcode and two fractions a, b.
// Output channel (out_valid/out_stall/out_data) returns exactly one result per beat.
// One beat at a time: in_stall is high from acceptance until the result has left.
// Negate and unused opcodes go straight to the finish state; compares take
// two products on one WORD_BITS x WORD_BITS signed multiplier; add, sub and
// mul pass through three multiplier states, mul leaving the third unused.
// Simplify and is-simplest run a binary gcd, one shift or subtract per cycle;
// simplify then adds two restoring divisions, of the numerator and then of the
// denominator magnitude by the gcd. The next beat is taken only once the
// result has left and the sequencer is back in idle.
// The result sits in an output register; while out_stall is high it holds
// unchanged and no new beat is taken.
// Reset (arst_n low) returns the sequencer to idle and drops out_valid.
// Fractions use the low WORD_BITS bits of each part, sign-extended; results are
// wrapped to WORD_BITS bits and sign-extended to 32.
module rational_arithmetic_unit #(
	parameter int WORD_BITS = rau_pkg::WORD_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  rau_pkg::in_beat_t  in_data,
	output logic               out_valid,
	input  logic               out_stall,
	output rau_pkg::out_beat_t out_data
);

	localparam int W = WORD_BITS;
	localparam int P = 2 * WORD_BITS;
	localparam int CW = $clog2(W + 1);

	typedef enum logic [9:0] {
		S_IDLE  = 10'b0000000001,
		S_MUL1  = 10'b0000000010,
		S_MUL2  = 10'b0000000100,
		S_MUL3  = 10'b0000001000,
		S_FIN   = 10'b0000010000,
		S_GPRE  = 10'b0000100000,
		S_GCD   = 10'b0001000000,
		S_DIVN  = 10'b0010000000,
		S_DIVD  = 10'b0100000000,
		S_OUT   = 10'b1000000000
	} state_t;

	state_t state_q;
	logic [3:0] op_q;
	logic signed [W-1:0] an_q, ad_q, bn_q, bd_q;
	logic signed [P-1:0] p1_q, p2_q, p3_q;
	logic [W:0] gx_q, gy_q;
	logic [CW-1:0] k_q;
	logic [W:0] g_q;
	logic [W-1:0] quo_q, rem_q, dvd_q;
	logic [CW-1:0] cnt_q;
	logic [W-1:0] qn_q;
	rau_pkg::out_beat_t res_q;
	logic out_valid_q;

	// shared multiplier
	logic signed [W-1:0] ma, mb;
	logic signed [P-1:0] mp;
	always_comb begin
		ma = an_q;
		mb = bd_q;
		case (state_q)
			S_MUL1: begin
				ma = an_q;
				mb = (op_q == rau_pkg::OP_MUL) ? bn_q : bd_q;
			end
			S_MUL2: begin
				ma = (op_q == rau_pkg::OP_MUL) ? ad_q : bn_q;
				mb = (op_q == rau_pkg::OP_MUL) ? bd_q : ad_q;
			end
			S_MUL3: begin
				ma = ad_q;
				mb = bd_q;
			end
			default: begin
				ma = an_q;
				mb = bd_q;
			end
		endcase
	end
	assign mp = P'(ma) * P'(mb);

	function automatic logic [31:0] sx32(input logic [W-1:0] v);
		return 32'(signed'(v));
	endfunction

	function automatic logic [W:0] absw(input logic signed [W-1:0] v);
		logic signed [W:0] e;
		e = (W+1)'(v);
		return e[W] ? (W+1)'(-e) : e;
	endfunction

	logic [W:0] an_mag, ad_mag;
	assign an_mag = absw(an_q);
	assign ad_mag = absw(ad_q);

	// restoring divide step, shared by both divisions
	logic [W:0] trial;
	logic [W-1:0] rsh;
	always_comb begin
		rsh = {rem_q[W-2:0], dvd_q[W-1]};
		trial = {1'b0, rsh} - g_q;
	end

	logic is_cmp;
	assign is_cmp = (op_q == rau_pkg::OP_EQ) || (op_q == rau_pkg::OP_GT) ||
		(op_q == rau_pkg::OP_LT);

	logic dz, sflip, gt, lt;
	assign dz = (ad_q == '0) || (bd_q == '0);
	assign sflip = ad_q[W-1] ^ bd_q[W-1];
	assign gt = p1_q > p2_q;
	assign lt = p1_q < p2_q;

	assign in_stall = (state_q != S_IDLE);
	assign out_valid = out_valid_q;
	assign out_data = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						op_q <= in_data.opcode;
						an_q <= in_data.a_num[W-1:0];
						ad_q <= in_data.a_den[W-1:0];
						bn_q <= in_data.b_num[W-1:0];
						bd_q <= in_data.b_den[W-1:0];
						res_q <= '0;
						case (in_data.opcode) inside
							rau_pkg::OP_ADD, rau_pkg::OP_SUB, rau_pkg::OP_MUL,
							rau_pkg::OP_EQ, rau_pkg::OP_GT, rau_pkg::OP_LT:
								state_q <= S_MUL1;
							rau_pkg::OP_SIMP, rau_pkg::OP_IS_SIMP:
								state_q <= S_GPRE;
							default: state_q <= S_FIN;
						endcase
					end
				end
				S_MUL1: begin
					p1_q <= mp;
					state_q <= S_MUL2;
				end
				S_MUL2: begin
					p2_q <= mp;
					state_q <= is_cmp ? S_FIN : S_MUL3;
				end
				S_MUL3: begin
					p3_q <= mp;
					state_q <= S_FIN;
				end
				S_FIN: begin
					case (op_q)
						rau_pkg::OP_ADD: begin
							res_q.res_num <= sx32(p1_q[W-1:0] + p2_q[W-1:0]);
							res_q.res_den <= sx32(p3_q[W-1:0]);
						end
						rau_pkg::OP_SUB: begin
							res_q.res_num <= sx32(p1_q[W-1:0] - p2_q[W-1:0]);
							res_q.res_den <= sx32(p3_q[W-1:0]);
						end
						rau_pkg::OP_MUL: begin
							res_q.res_num <= sx32(p1_q[W-1:0]);
							res_q.res_den <= sx32(p2_q[W-1:0]);
						end
						rau_pkg::OP_NEG: begin
							res_q.res_num <= sx32(W'(-an_q));
							res_q.res_den <= sx32(ad_q);
						end
						rau_pkg::OP_EQ:
							res_q.flag <= dz ? ((an_q == bn_q) && (ad_q == bd_q)) :
								(p1_q == p2_q);
						rau_pkg::OP_GT:
							res_q.flag <= !dz && (sflip ? lt : gt);
						rau_pkg::OP_LT:
							res_q.flag <= !dz && (sflip ? gt : lt);
						default: res_q <= '0;
					endcase
					state_q <= S_OUT;
				end
				S_GPRE: begin
					gx_q <= an_mag;
					gy_q <= ad_mag;
					k_q <= '0;
					state_q <= S_GCD;
				end
				S_GCD: begin
					// binary gcd, one step per cycle
					if (gx_q == '0 || gy_q == '0) begin
						g_q <= (gx_q | gy_q) << k_q;
						cnt_q <= '0;
						rem_q <= '0;
						dvd_q <= an_mag[W-1:0];
						if ((gx_q | gy_q) == '0) begin
							res_q.status <= (op_q == rau_pkg::OP_SIMP);
							res_q.res_num <= (op_q == rau_pkg::OP_SIMP) ? sx32(an_q) : '0;
							res_q.res_den <= (op_q == rau_pkg::OP_SIMP) ? sx32(ad_q) : '0;
							state_q <= S_OUT;
						end else if (op_q != rau_pkg::OP_SIMP) begin
							res_q.flag <= (((gx_q | gy_q) << k_q) == (W+1)'(1));
							state_q <= S_OUT;
						end else begin
							state_q <= S_DIVN;
						end
					end else if (!gx_q[0] && !gy_q[0]) begin
						gx_q <= gx_q >> 1;
						gy_q <= gy_q >> 1;
						k_q <= k_q + CW'(1);
					end else if (!gx_q[0]) begin
						gx_q <= gx_q >> 1;
					end else if (!gy_q[0]) begin
						gy_q <= gy_q >> 1;
					end else if (gx_q >= gy_q) begin
						gx_q <= (gx_q - gy_q) >> 1;
					end else begin
						gy_q <= (gy_q - gx_q) >> 1;
					end
				end
				S_DIVN, S_DIVD: begin
					dvd_q <= {dvd_q[W-2:0], 1'b0};
					if (!trial[W]) begin
						rem_q <= trial[W-1:0];
						quo_q <= {quo_q[W-2:0], 1'b1};
					end else begin
						rem_q <= rsh;
						quo_q <= {quo_q[W-2:0], 1'b0};
					end
					cnt_q <= cnt_q + CW'(1);
					if (cnt_q == CW'(W - 1)) begin
						cnt_q <= '0;
						rem_q <= '0;
						if (state_q == S_DIVN) begin
							qn_q <= {quo_q[W-2:0], !trial[W]};
							dvd_q <= ad_mag[W-1:0];
							state_q <= S_DIVD;
						end else begin
							res_q.res_num <= sx32(an_q[W-1] ? W'(-qn_q) : qn_q);
							res_q.res_den <= sx32(ad_q[W-1] ?
								W'(-{quo_q[W-2:0], !trial[W]}) : {quo_q[W-2:0], !trial[W]});
							state_q <= S_OUT;
						end
					end
				end
				S_OUT: begin
					out_valid_q <= 1'b1;
					if (out_valid_q && !out_stall) begin
						out_valid_q <= 1'b0;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

`ifndef NO_ASSERTIONS
	a_onehot: assert property (@(posedge clk) disable iff (!arst_n) $onehot(state_q))
		else $error("state not one-hot");
	a_valid_out: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> state_q == S_OUT)
		else $error("out_valid outside output state");
	a_one_result: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_stall) |=> !out_valid)
		else $error("result repeated");
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("beat taken while busy");
`endif

endmodule
